// File: rtl/core/ieval_pkg.sv
// shared types, character codes and error helpers for the infix evaluator
`timescale 1ns / 1ps
package ieval_pkg;

	localparam int STACK_DEPTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF   = 48;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DIV   = 8'h2f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_OPEN = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DIVZ    = 3'd1,
		ST_SAT     = 3'd2,
		ST_STKOVF  = 3'd3,
		ST_MALFORM = 3'd4
	} status_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic    done;
		status_t code;
	} alu_rsp_t;

	function automatic logic is_fatal(status_t s);
		return (s != ST_OK) && (s != ST_SAT);
	endfunction

	// a fatal code replaces saturation, never another fatal code
	function automatic status_t note_err(status_t cur, status_t c);
		if (cur == ST_OK || (cur == ST_SAT && c != ST_SAT)) begin
			return c;
		end
		return cur;
	endfunction

endpackage

// File: rtl/core/ieval_stack.sv
// single-port-write, single-port-read stack memory with registered read
`timescale 1ns / 1ps
module ieval_stack #(
	parameter int WIDTH = ieval_pkg::VALUE_WIDTH_DEF,
	parameter int DEPTH = ieval_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	import ieval_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/ieval_alu.sv
// multi-cycle arithmetic unit: add/sub, shift-add multiply, restoring divide, saturation
`timescale 1ns / 1ps
module ieval_alu #(
	parameter int VW = ieval_pkg::VALUE_WIDTH_DEF,
	parameter int FB = ieval_pkg::FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ieval_pkg::alu_req_t  req,
	input  logic signed [VW-1:0] a,
	input  logic signed [VW-1:0] b,
	output ieval_pkg::alu_rsp_t  rsp,
	output logic signed [VW-1:0] result
);
	import ieval_pkg::*;

	localparam int QW = VW + FB;
	localparam int MW = 2 * VW + FB;
	localparam int NW = $clog2(QW + 1);

	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_MUL  = 4'b0010,
		A_DIV  = 4'b0100,
		A_FIN  = 4'b1000
	} alu_state_t;

	alu_state_t      state_q;
	logic [NW-1:0]   cnt_q;
	op_t             op_q;
	logic            neg_q;
	logic            divz_q;
	logic [VW-1:0]   ma_q;
	logic [VW-1:0]   mb_q;
	logic [VW:0]     sum_mag_q;
	logic [VW:0]     hi_q;
	logic [VW-1:0]   lo_q;
	logic [QW-1:0]   quo_q;
	logic [VW:0]     rem_q;

	logic [VW-1:0]   ma_in;
	logic [VW-1:0]   mb_in;
	logic [VW:0]     sum_s;
	logic [VW:0]     sum_mag;
	logic [VW:0]     mul_s;
	logic [VW:0]     rs;
	logic            ge;
	logic [VW:0]     rem_n;
	logic [2*VW-1:0] prod;
	logic [MW-1:0]   mag;
	logic [MW-1:0]   lim;
	logic [MW-1:0]   clamped;
	logic [VW-1:0]   mv;
	logic            sat;

	assign ma_in   = a[VW-1] ? (~a + 1'b1) : a;
	assign mb_in   = b[VW-1] ? (~b + 1'b1) : b;
	assign sum_s   = (req.op == OP_SUB) ? ({a[VW-1], a} - {b[VW-1], b})
	                                    : ({a[VW-1], a} + {b[VW-1], b});
	assign sum_mag = sum_s[VW] ? (~sum_s + 1'b1) : sum_s;

	assign mul_s = hi_q + (lo_q[0] ? {1'b0, ma_q} : '0);

	assign rs    = {rem_q[VW-1:0], quo_q[QW-1]};
	assign ge    = rs >= {1'b0, mb_q};
	assign rem_n = ge ? (rs - {1'b0, mb_q}) : rs;

	assign prod = {hi_q[VW-1:0], lo_q};

	always_comb begin
		unique case (op_q)
			OP_MUL:  mag = MW'(prod >> FB);
			OP_DIV:  mag = MW'(quo_q);
			default: mag = MW'(sum_mag_q);
		endcase
	end

	assign lim     = neg_q ? (MW'(1) << (VW - 1)) : ((MW'(1) << (VW - 1)) - MW'(1));
	assign sat     = mag > lim;
	assign clamped = sat ? lim : mag;
	assign mv      = clamped[VW-1:0];

	assign result   = divz_q ? '0 : (neg_q ? (~mv + 1'b1) : mv);
	assign rsp.done = (state_q == A_FIN);
	assign rsp.code = divz_q ? ST_DIVZ : (sat ? ST_SAT : ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					cnt_q <= '0;
					if (req.start) begin
						if (req.op == OP_MUL) begin
							state_q <= A_MUL;
						end else if (req.op == OP_DIV && b != '0) begin
							state_q <= A_DIV;
						end else begin
							state_q <= A_FIN;
						end
					end
				end
				A_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == NW'(VW - 1)) begin
						state_q <= A_FIN;
					end
				end
				A_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == NW'(QW - 1)) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && req.start) begin
			op_q      <= req.op;
			neg_q     <= (req.op == OP_ADD || req.op == OP_SUB) ? sum_s[VW]
			                                                    : (a[VW-1] ^ b[VW-1]);
			divz_q    <= (req.op == OP_DIV) && (b == '0);
			ma_q      <= ma_in;
			mb_q      <= mb_in;
			sum_mag_q <= sum_mag;
			hi_q      <= '0;
			lo_q      <= mb_in;
			quo_q     <= QW'(ma_in) << FB;
			rem_q     <= '0;
		end else if (state_q == A_MUL) begin
			hi_q <= {1'b0, mul_s[VW:1]};
			lo_q <= {mul_s[0], lo_q[VW-1:1]};
		end else if (state_q == A_DIV) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

endmodule

// File: rtl/core/infix_expression_evaluator.sv
// top level: two-stack infix expression evaluator with sequencer and output register
//
//   channel  signals                          direction  word
//   in       in_valid, in_ready, symbol       into block one ascii character
//   out      out_valid, out_ready, value,     out        one result per closed
//            status                                      expression
//
// a digit either starts a new operand or extends the top one; '(' is pushed directly;
// any other operator runs the reduce loop, where each reduction combines the top two operands
// under the top operator in the arithmetic unit, which takes longest for divide, then multiply
// the closing marker checks and emits after its reductions, and waits while a result is held
// reset clears all counts, flags and the frame state; stack memories are not cleared
// in_ready drops while a symbol is being worked; output stalls only hold a closing marker
`timescale 1ns / 1ps
module infix_expression_evaluator #(
	parameter int STACK_DEPTH   = ieval_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH   = ieval_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = ieval_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    symbol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] value,
	output logic [2:0]                    status
);
	import ieval_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int FB = FRACTION_BITS;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int DW = VW + FB + 5;
	localparam logic [VW-1:0] VMAX = {1'b0, {(VW - 1){1'b1}}};

	// sequencer states
	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_DISP    = 11'b00000000010,
		S_DACC    = 11'b00000000100,
		S_LOOP    = 11'b00000001000,
		S_OPCHK   = 11'b00000010000,
		S_RDA     = 11'b00000100000,
		S_ALUGO   = 11'b00001000000,
		S_ALUWAIT = 11'b00010000000,
		S_FIN     = 11'b00100000000,
		S_EMIT    = 11'b01000000000,
		S_SPARE   = 11'b10000000000
	} state_t;

	// what ends the reduce loop and what happens after it
	typedef enum logic [1:0] {
		MD_ADD   = 2'd0,
		MD_MUL   = 2'd1,
		MD_PAREN = 2'd2,
		MD_CLOSE = 2'd3
	} mode_t;

	state_t               state_q, state_d;
	logic                 phase_q, phase_d;
	logic                 in_num_q, in_num_d;
	status_t              err_q, err_d;
	logic [CW-1:0]        opnd_cnt_q, opnd_cnt_d;
	logic [CW-1:0]        optr_cnt_q, optr_cnt_d;
	mode_t                mode_q, mode_d;
	op_t                  push_op_q, push_op_d;
	op_t                  op_q, op_d;
	logic [7:0]           sym_q;
	logic signed [VW-1:0] b_q;
	logic                 out_valid_q;
	logic signed [VW-1:0] value_q;
	status_t              status_q;

	logic [CW-1:0] opnd_dec;
	logic [CW-1:0] optr_dec;

	// stack memory ports
	logic          opnd_we, opnd_re;
	logic [AW-1:0] opnd_waddr, opnd_raddr;
	logic [VW-1:0] opnd_wdata, opnd_rdata;
	logic          optr_we, optr_re;
	logic [AW-1:0] optr_waddr, optr_raddr;
	logic [2:0]    optr_wdata, optr_rdata;

	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;
	logic signed [VW-1:0] alu_result;

	// digit accumulation
	logic [3:0]    digit;
	logic [DW-1:0] d_wide;
	logic [DW-1:0] acc;
	logic          acc_sat;
	logic          emit;

	assign opnd_dec = opnd_cnt_q - CW'(1);
	assign optr_dec = optr_cnt_q - CW'(1);
	assign digit    = sym_q[3:0];
	assign d_wide   = DW'(digit) << FB;
	assign acc      = (DW'(opnd_rdata) << 3) + (DW'(opnd_rdata) << 1) + d_wide;
	assign acc_sat  = acc > DW'(VMAX);

	ieval_stack #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_opnd (
		.clk     (clk),
		.wr_en   (opnd_we),
		.wr_addr (opnd_waddr),
		.wr_data (opnd_wdata),
		.rd_en   (opnd_re),
		.rd_addr (opnd_raddr),
		.rd_data (opnd_rdata)
	);

	ieval_stack #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_optr (
		.clk     (clk),
		.wr_en   (optr_we),
		.wr_addr (optr_waddr),
		.wr_data (optr_wdata),
		.rd_en   (optr_re),
		.rd_addr (optr_raddr),
		.rd_data (optr_rdata)
	);

	ieval_alu #(.VW(VW), .FB(FB)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (opnd_rdata),
		.b      (b_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	always_comb begin
		op_t  top_op;
		logic do_red;
		state_d    = state_q;
		phase_d    = phase_q;
		in_num_d   = in_num_q;
		err_d      = err_q;
		opnd_cnt_d = opnd_cnt_q;
		optr_cnt_d = optr_cnt_q;
		mode_d     = mode_q;
		push_op_d  = push_op_q;
		op_d       = op_q;
		opnd_we    = 1'b0;
		opnd_waddr = opnd_cnt_q[AW-1:0];
		opnd_wdata = d_wide[VW-1:0];
		opnd_re    = 1'b0;
		opnd_raddr = opnd_dec[AW-1:0];
		optr_we    = 1'b0;
		optr_waddr = optr_cnt_q[AW-1:0];
		optr_wdata = push_op_q;
		optr_re    = 1'b0;
		optr_raddr = optr_dec[AW-1:0];
		alu_req.start = 1'b0;
		alu_req.op    = op_q;
		emit   = 1'b0;
		top_op = op_t'(optr_rdata);
		do_red = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_IDLE;
				if (!phase_q) begin
					// outside a frame only the opening marker counts
					if (sym_q == CH_HASH) begin
						opnd_cnt_d = '0;
						optr_cnt_d = '0;
						in_num_d   = 1'b0;
						err_d      = ST_OK;
						phase_d    = 1'b1;
					end
				end else if (sym_q == CH_HASH) begin
					mode_d  = MD_CLOSE;
					state_d = S_LOOP;
				end else if (is_fatal(err_q)) begin
					state_d = S_IDLE;
				end else if (sym_q >= CH_ZERO && sym_q <= CH_NINE) begin
					if (!in_num_q) begin
						if (opnd_cnt_q >= CW'(STACK_DEPTH)) begin
							err_d = note_err(err_q, ST_STKOVF);
						end else begin
							opnd_we    = 1'b1;
							opnd_cnt_d = opnd_cnt_q + CW'(1);
						end
						in_num_d = !is_fatal(err_d);
					end else begin
						opnd_re = 1'b1;
						state_d = S_DACC;
					end
				end else begin
					in_num_d = 1'b0;
					unique case (sym_q)
						CH_PLUS, CH_MINUS: begin
							mode_d    = MD_ADD;
							push_op_d = (sym_q == CH_PLUS) ? OP_ADD : OP_SUB;
							state_d   = S_LOOP;
						end
						CH_MUL, CH_DIV: begin
							mode_d    = MD_MUL;
							push_op_d = (sym_q == CH_MUL) ? OP_MUL : OP_DIV;
							state_d   = S_LOOP;
						end
						CH_CLOSE: begin
							mode_d  = MD_PAREN;
							state_d = S_LOOP;
						end
						CH_OPEN: begin
							if (optr_cnt_q >= CW'(STACK_DEPTH)) begin
								err_d = note_err(err_q, ST_STKOVF);
							end else begin
								optr_we    = 1'b1;
								optr_wdata = OP_OPEN;
								optr_cnt_d = optr_cnt_q + CW'(1);
							end
						end
						default: begin
							err_d = note_err(err_q, ST_MALFORM);
						end
					endcase
				end
			end
			S_DACC: begin
				// top of operand stack is being extended by one decimal digit
				opnd_we    = 1'b1;
				opnd_waddr = opnd_dec[AW-1:0];
				opnd_wdata = acc_sat ? VMAX : acc[VW-1:0];
				if (acc_sat) begin
					err_d = note_err(err_q, ST_SAT);
				end
				state_d = S_IDLE;
			end
			S_LOOP: begin
				if (is_fatal(err_q) || optr_cnt_q == '0) begin
					state_d = S_FIN;
				end else begin
					optr_re = 1'b1;
					state_d = S_OPCHK;
				end
			end
			S_OPCHK: begin
				unique case (mode_q)
					MD_CLOSE: begin
						if (top_op == OP_OPEN) begin
							err_d   = note_err(err_q, ST_MALFORM);
							state_d = S_LOOP;
						end else begin
							do_red = 1'b1;
						end
					end
					MD_MUL: begin
						if (top_op == OP_MUL || top_op == OP_DIV) begin
							do_red = 1'b1;
						end else begin
							state_d = S_FIN;
						end
					end
					default: begin
						if (top_op == OP_OPEN) begin
							state_d = S_FIN;
						end else begin
							do_red = 1'b1;
						end
					end
				endcase
				if (do_red) begin
					if (opnd_cnt_q < CW'(2)) begin
						err_d   = note_err(err_q, ST_MALFORM);
						state_d = S_LOOP;
					end else begin
						// pop operator and right operand, fetch right operand
						op_d       = top_op;
						optr_cnt_d = optr_dec;
						opnd_cnt_d = opnd_dec;
						opnd_re    = 1'b1;
						state_d    = S_RDA;
					end
				end
			end
			S_RDA: begin
				// fetch left operand, now the new top
				opnd_re = 1'b1;
				state_d = S_ALUGO;
			end
			S_ALUGO: begin
				alu_req.start = 1'b1;
				state_d       = S_ALUWAIT;
			end
			S_ALUWAIT: begin
				if (alu_rsp.done) begin
					if (alu_rsp.code == ST_DIVZ) begin
						err_d = note_err(err_q, ST_DIVZ);
					end else begin
						if (alu_rsp.code == ST_SAT) begin
							err_d = note_err(err_q, ST_SAT);
						end
						opnd_we    = 1'b1;
						opnd_waddr = opnd_dec[AW-1:0];
						opnd_wdata = alu_result;
					end
					state_d = S_LOOP;
				end
			end
			S_FIN: begin
				state_d = S_IDLE;
				unique case (mode_q)
					MD_CLOSE: begin
						if (!is_fatal(err_q) && opnd_cnt_q != CW'(1)) begin
							err_d = note_err(err_q, ST_MALFORM);
						end
						opnd_re    = 1'b1;
						opnd_raddr = '0;
						state_d    = S_EMIT;
					end
					MD_PAREN: begin
						if (!is_fatal(err_q)) begin
							if (optr_cnt_q == '0) begin
								err_d = note_err(err_q, ST_MALFORM);
							end else begin
								optr_cnt_d = optr_dec;
							end
						end
					end
					default: begin
						if (!is_fatal(err_q)) begin
							if (optr_cnt_q >= CW'(STACK_DEPTH)) begin
								err_d = note_err(err_q, ST_STKOVF);
							end else begin
								optr_we    = 1'b1;
								optr_cnt_d = optr_cnt_q + CW'(1);
							end
						end
					end
				endcase
			end
			S_EMIT: begin
				// wait for the output register, then reset the frame
				if (!out_valid_q) begin
					emit       = 1'b1;
					opnd_cnt_d = '0;
					optr_cnt_d = '0;
					in_num_d   = 1'b0;
					err_d      = ST_OK;
					phase_d    = 1'b0;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			in_num_q    <= 1'b0;
			err_q       <= ST_OK;
			opnd_cnt_q  <= '0;
			optr_cnt_q  <= '0;
			mode_q      <= MD_ADD;
			push_op_q   <= OP_ADD;
			op_q        <= OP_ADD;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			in_num_q   <= in_num_d;
			err_q      <= err_d;
			opnd_cnt_q <= opnd_cnt_d;
			optr_cnt_q <= optr_cnt_d;
			mode_q     <= mode_d;
			push_op_q  <= push_op_d;
			op_q       <= op_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sym_q <= symbol;
		end
		if (state_q == S_RDA) begin
			b_q <= opnd_rdata;
		end
		if (emit) begin
			value_q  <= is_fatal(err_q) ? '0 : opnd_rdata;
			status_q <= err_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_opnd_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		opnd_cnt_q <= CW'(STACK_DEPTH))
		else $error("operand count beyond stack depth");
	a_optr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		optr_cnt_q <= CW'(STACK_DEPTH))
		else $error("operator count beyond stack depth");
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (opnd_cnt_q == '0 && optr_cnt_q == '0 && !phase_q))
		else $error("frame not cleared after result");
	a_fatal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_DIVZ || status_q == ST_STKOVF ||
		status_q == ST_MALFORM)) |-> (value_q == '0))
		else $error("nonzero value under fatal status");
	a_alu_done: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_ALUWAIT))
		else $error("arithmetic result with no reduction waiting");
`endif

endmodule
